### rtl/pbrld_pkg.sv
package pbrld_pkg;

    localparam int unsigned LANE_MAX   = 4;
    localparam int unsigned MAX_BEATS  = 32;
    localparam int unsigned BEAT_W     = $clog2(MAX_BEATS);
    localparam logic [7:0]  HDR_SKIP   = 8'h80;
    localparam logic [7:0]  HDR_REP_LO = 8'h81;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_LITERAL,
        ST_REPEAT_BYTE,
        ST_REPEAT_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic load_hdr;
        logic emit_hdr_end;
        logic emit_lit;
        logic latch_rep;
        logic emit_rep;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic hdr_literal;
        logic hdr_repeat;
        logic lit_last;
        logic rep_fin;
    } t_dp_status;

endpackage

### rtl/pbrld_in_if.sv
interface pbrld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

### rtl/pbrld_out_if.sv
interface pbrld_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] lane0;
    logic [7:0] lane1;
    logic [7:0] lane2;
    logic [7:0] lane3;
    logic [2:0] lanes_valid;
    logic       run_last;
    logic       stream_done;
    logic       truncated;

    modport source (
        output valid, output lane0, output lane1, output lane2, output lane3,
        output lanes_valid, output run_last, output stream_done, output truncated,
        input ready
    );
    modport sink (
        input valid, input lane0, input lane1, input lane2, input lane3,
        input lanes_valid, input run_last, input stream_done, input truncated,
        output ready
    );
endinterface

### rtl/pbrld_ctrl.sv
module pbrld_ctrl
    import pbrld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_stream_end,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && o_cmd.in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEADER;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_HEADER: begin
                if (accept && !i_stream_end) begin
                    if (i_status.hdr_literal) begin
                        n_state = ST_LITERAL;
                    end else if (i_status.hdr_repeat) begin
                        n_state = ST_REPEAT_BYTE;
                    end
                end
            end
            ST_LITERAL: begin
                if (accept && (i_stream_end || i_status.lit_last)) begin
                    n_state = ST_HEADER;
                end
            end
            ST_REPEAT_BYTE: begin
                if (accept) begin
                    n_state = ST_REPEAT_EMIT;
                end
            end
            ST_REPEAT_EMIT: begin
                if (i_status.out_free && i_status.rep_fin) begin
                    n_state = ST_HEADER;
                end
            end
            default: n_state = ST_HEADER;
        endcase
    end

    always_comb begin
        o_cmd              = '0;
        o_cmd.in_ready     = (r_state != ST_REPEAT_EMIT) && i_status.out_free;
        o_cmd.load_hdr     = i_in_valid && o_cmd.in_ready && (r_state == ST_HEADER);
        o_cmd.emit_hdr_end = o_cmd.load_hdr && i_stream_end;
        o_cmd.emit_lit     = i_in_valid && o_cmd.in_ready && (r_state == ST_LITERAL);
        o_cmd.latch_rep    = i_in_valid && o_cmd.in_ready && (r_state == ST_REPEAT_BYTE);
        o_cmd.emit_rep     = (r_state == ST_REPEAT_EMIT) && i_status.out_free;
    end

endmodule

### rtl/pbrld_datapath.sv
module pbrld_datapath
    import pbrld_pkg::*;
#(
    parameter int unsigned LANE_W = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    input  logic        i_out_ready,
    input  t_ctrl_cmd   i_cmd,
    output t_dp_status  o_status,
    output logic [7:0]  o_lane0,
    output logic [7:0]  o_lane1,
    output logic [7:0]  o_lane2,
    output logic [7:0]  o_lane3,
    output logic [2:0]  o_lanes_valid,
    output logic        o_run_last,
    output logic        o_stream_done,
    output logic        o_truncated,
    output logic        o_out_valid
);

    localparam logic [2:0] W = 3'(LANE_W);

    logic [7:0]        r_rem,   n_rem;
    logic [7:0]        r_byte;
    logic              r_end;
    logic [BEAT_W-1:0] r_beats;

    logic [7:0] r_lane [LANE_MAX];
    logic [7:0] n_lane [LANE_MAX];
    logic [2:0] r_lanes_valid, n_lanes_valid;
    logic       r_run_last, n_run_last;
    logic       r_done, n_done;
    logic       r_trunc, n_trunc;
    logic       r_out_valid;

    logic [2:0] rep_n;
    logic       load_out;

    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_status.hdr_literal = !i_data_byte[7];
    assign o_status.hdr_repeat  = i_data_byte >= HDR_REP_LO;
    assign o_status.lit_last    = (r_rem == 8'd1);
    assign o_status.rep_fin     = (r_rem <= {5'd0, W}) || (r_beats == BEAT_W'(MAX_BEATS - 1));

    assign rep_n    = (r_rem < {5'd0, W}) ? r_rem[2:0] : W;
    assign load_out = i_cmd.emit_hdr_end || i_cmd.emit_lit || i_cmd.emit_rep;

    always_comb begin
        n_rem = r_rem;
        if (i_cmd.load_hdr) begin
            if (!i_data_byte[7]) begin
                n_rem = i_data_byte + 8'd1;
            end else begin
                n_rem = 8'(9'd257 - {1'b0, i_data_byte});
            end
        end else if (i_cmd.emit_lit) begin
            n_rem = r_rem - 8'd1;
        end else if (i_cmd.emit_rep) begin
            n_rem = r_rem - {5'd0, rep_n};
        end
    end

    always_comb begin
        for (int i = 0; i < LANE_MAX; i++) begin
            n_lane[i] = 8'd0;
        end
        n_lanes_valid = 3'd0;
        n_run_last    = 1'b0;
        n_done        = 1'b0;
        n_trunc       = 1'b0;
        if (i_cmd.emit_hdr_end) begin
            // empty beat closing the stream; a skip header is not a cut run
            n_done  = 1'b1;
            n_trunc = (i_data_byte != HDR_SKIP);
        end else if (i_cmd.emit_lit) begin
            n_lane[0]     = i_data_byte;
            n_lanes_valid = 3'd1;
            n_run_last    = o_status.lit_last;
            n_done        = i_stream_end;
            n_trunc       = i_stream_end && !o_status.lit_last;
        end else begin
            for (int i = 0; i < LANE_MAX; i++) begin
                n_lane[i] = (3'(i) < rep_n) ? r_byte : 8'd0;
            end
            n_lanes_valid = rep_n;
            n_run_last    = o_status.rep_fin;
            n_done        = o_status.rep_fin && r_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= 8'd0;
            r_beats     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rem <= n_rem;
            if (i_cmd.latch_rep) begin
                r_beats <= '0;
            end else if (i_cmd.emit_rep) begin
                r_beats <= r_beats + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_rep) begin
            r_byte <= i_data_byte;
            r_end  <= i_stream_end;
        end
        if (load_out) begin
            for (int i = 0; i < LANE_MAX; i++) begin
                r_lane[i] <= n_lane[i];
            end
            r_lanes_valid <= n_lanes_valid;
            r_run_last    <= n_run_last;
            r_done        <= n_done;
            r_trunc       <= n_trunc;
        end
    end

    assign o_lane0       = r_lane[0];
    assign o_lane1       = r_lane[1];
    assign o_lane2       = r_lane[2];
    assign o_lane3       = r_lane[3];
    assign o_lanes_valid = r_lanes_valid;
    assign o_run_last    = r_run_last;
    assign o_stream_done = r_done;
    assign o_truncated   = r_trunc;
    assign o_out_valid   = r_out_valid;

endmodule

### rtl/packbits_run_length_decoder.sv
// Channel   Dir  Payload                                       Transaction
// i_in      in   data_byte[7:0], stream_end                    valid & ready
// o_out     out  lane0..lane3[7:0], lanes_valid[2:0],          valid & ready
//                run_last, stream_done, truncated
//
// One decoded beat is emitted per literal byte. A repeat run is sent in beats of
// up to W lanes, at most 32 beats, W being LANES clamped to 1..4: the repeat
// emitter sends one beat per cycle while the output is free and holds off input
// until its last beat is loaded.
// i_rst_n is synchronous, active low; it returns the decoder to expecting a header.
// A stalled output holds its beat; input is taken only when the output register
// is empty or being drained in the same cycle.
module packbits_run_length_decoder
    import pbrld_pkg::*;
#(
    parameter int unsigned LANES = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pbrld_in_if.sink      i_in,
    pbrld_out_if.source   o_out
);

    localparam int unsigned LANE_W = (LANES < 1) ? 1 :
                                     (LANES > LANE_MAX) ? LANE_MAX : LANES;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    pbrld_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_stream_end (i_in.stream_end),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    pbrld_datapath #(
        .LANE_W (LANE_W)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_in.data_byte),
        .i_stream_end  (i_in.stream_end),
        .i_out_ready   (o_out.ready),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_lane0       (o_out.lane0),
        .o_lane1       (o_out.lane1),
        .o_lane2       (o_out.lane2),
        .o_lane3       (o_out.lane3),
        .o_lanes_valid (o_out.lanes_valid),
        .o_run_last    (o_out.run_last),
        .o_stream_done (o_out.stream_done),
        .o_truncated   (o_out.truncated),
        .o_out_valid   (o_out.valid)
    );

    assign i_in.ready = cmd.in_ready;

`ifndef NO_ASSERTIONS
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.emit_hdr_end, cmd.emit_lit, cmd.emit_rep}))
        else $error("more than one beat source in a cycle");

    a_no_input_during_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_rep |-> !cmd.in_ready)
        else $error("input taken while a repeat is being emitted");

    a_trunc_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.truncated) |-> o_out.stream_done)
        else $error("truncation flagged without stream end");

    a_lane_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.lanes_valid <= 3'(LANE_W)))
        else $error("beat carries more lanes than configured");
`endif

endmodule
